// File: design/cps_pkg.sv
package cps_pkg;

  // Column count store.
  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register widths and indexes.
  localparam int WIDTH_REG_W  = 10;
  localparam int HEIGHT_REG_W = 11;
  localparam int LEVEL_W      = 8;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND_LEVEL = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 10'd512;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 11'd1024;
  localparam logic [LEVEL_W-1:0]      LEVEL_RESET  = 8'd255;

  // Result field widths.
  localparam int START_W = 9;
  localparam int END_W   = 10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FLUSH,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

endpackage

// File: design/cps_count_ram.sv
module cps_count_ram
  import cps_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  ram_ctl_t           ctl,
  input  logic [AW-1:0]      waddr,
  input  logic [COUNT_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [DEPTH];

  // Read-first: a read and a write of the same entry at one edge return the old value.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/cps_accum.sv
module cps_accum
  import cps_pkg::*;
#(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 1024,
  parameter int COL_W       = $clog2(MAX_COLUMNS),
  parameter int ROW_W       = $clog2(MAX_ROWS),
  parameter int WCNT_W      = $clog2(MAX_COLUMNS + 1),
  parameter int HCNT_W      = $clog2(MAX_ROWS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [LEVEL_W-1:0] pixel,
  input  logic [LEVEL_W-1:0] fg_level,
  input  logic [WCNT_W-1:0]  w_eff,
  input  logic [HCNT_W-1:0]  h_eff,
  input  logic [COUNT_W-1:0] rdata,
  output ram_ctl_t           ctl,
  output logic [COL_W-1:0]   raddr,
  output logic [COL_W-1:0]   waddr,
  output logic [COUNT_W-1:0] wdata,
  output logic               frame_end
);

  logic [COL_W-1:0]   col_pos;
  logic [ROW_W-1:0]   row_pos;
  logic               last_col;
  logic               last_row;
  logic               s1_valid;
  logic [COL_W-1:0]   s1_addr;
  logic               s1_hit;
  logic               fwd_valid;
  logic [COL_W-1:0]   fwd_addr;
  logic [COUNT_W-1:0] fwd_data;
  logic [COUNT_W-1:0] cur;

  // A position at or past the last column or row counts as the last one.
  assign last_col  = (WCNT_W'(col_pos) + WCNT_W'(1)) >= w_eff;
  assign last_row  = (HCNT_W'(row_pos) + HCNT_W'(1)) >= h_eff;
  assign frame_end = accept && last_col && last_row;

  // The write at the previous edge is not visible to a read issued at that edge.
  assign cur   = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rdata;
  assign wdata = (s1_hit && cur != COUNT_MAX) ? cur + COUNT_W'(1) : cur;

  assign raddr     = col_pos;
  assign waddr     = s1_addr;
  assign ctl.rd_en = accept;
  assign ctl.wr_en = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      row_pos   <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= accept;
      fwd_valid <= s1_valid;
      if (accept) begin
        if (last_col) begin
          col_pos <= '0;
          row_pos <= last_row ? '0 : row_pos + ROW_W'(1);
        end else begin
          col_pos <= col_pos + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= col_pos;
    s1_hit   <= (pixel == fg_level);
    fwd_addr <= s1_addr;
    fwd_data <= wdata;
  end

endmodule

// File: design/cps_scan.sv
module cps_scan
  import cps_pkg::*;
#(
  parameter int MAX_COLUMNS  = 512,
  parameter int MAX_SEGMENTS = 64,
  parameter int COL_W        = $clog2(MAX_COLUMNS),
  parameter int WCNT_W       = $clog2(MAX_COLUMNS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WCNT_W-1:0]  w_eff,
  input  logic [COUNT_W-1:0] rdata,
  output ram_ctl_t           ctl,
  output logic [COL_W-1:0]   addr,
  output logic               idle,
  output logic               m_valid,
  input  logic               m_ready,
  output logic [START_W-1:0] seg_start,
  output logic [END_W-1:0]   seg_end,
  output logic               seg_valid,
  output logic               seg_final,
  output logic               seg_dropped
);

  localparam int SC_W   = $clog2(MAX_COLUMNS + 2);
  localparam int EMIT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [SC_W-1:0]   LAST_SC  = SC_W'(MAX_COLUMNS);
  localparam logic [SC_W-1:0]   DONE_SC  = SC_W'(MAX_COLUMNS + 1);
  localparam logic [SC_W-1:0]   CLEAR_SC = SC_W'(MAX_COLUMNS - 1);
  localparam logic [EMIT_W-1:0] EMIT_MAX = EMIT_W'(MAX_SEGMENTS);

  state_t state, state_next;

  logic [SC_W-1:0]   sc;
  logic              s1_valid;
  logic [SC_W-1:0]   s1_col;
  logic              in_run;
  logic [COL_W-1:0]  run_start;
  logic [EMIT_W-1:0] emitted;
  logic              dropped;
  logic              pend_valid;
  logic [COL_W-1:0]  pend_start;
  logic [SC_W-1:0]   pend_end;

  logic nz, close, produce, push, stall, s1_fire, issue, out_free, scan_done;

  // The column after the last real one reads as empty and closes a run at the edge.
  assign nz        = s1_col < SC_W'(w_eff) && rdata != '0;
  assign close     = s1_valid && in_run && !nz;
  assign produce   = close && emitted < EMIT_MAX;
  assign push      = produce && pend_valid;
  assign out_free  = !m_valid || m_ready;
  assign stall     = push && !out_free;
  assign s1_fire   = s1_valid && !stall;
  assign issue     = state == ST_SCAN && sc <= LAST_SC && (!s1_valid || s1_fire);
  assign scan_done = sc == DONE_SC && (!s1_valid || s1_fire);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (sc == CLEAR_SC) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_FLUSH;
      ST_FLUSH:  state_next = ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl.rd_en = 1'b0;
    ctl.wr_en = 1'b0;
    idle      = 1'b0;
    case (state)
      ST_CLEAR: begin
        ctl.wr_en = 1'b1;
      end
      ST_IDLE: begin
        idle = 1'b1;
      end
      ST_SCAN: begin
        ctl.rd_en = issue && sc < LAST_SC;
        ctl.wr_en = issue && sc < LAST_SC;
      end
      default: begin
        ctl.rd_en = 1'b0;
      end
    endcase
  end

  assign addr = sc[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sc         <= '0;
      s1_valid   <= 1'b0;
      in_run     <= 1'b0;
      emitted    <= '0;
      dropped    <= 1'b0;
      pend_valid <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: sc <= (sc == CLEAR_SC) ? '0 : sc + SC_W'(1);
        ST_SCAN:  if (issue) sc <= sc + SC_W'(1);
        default:  sc <= '0;
      endcase

      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (state == ST_SCAN && s1_fire) begin
        if (!in_run && nz) begin
          in_run <= 1'b1;
        end else if (close) begin
          in_run <= 1'b0;
          if (produce) begin
            emitted    <= emitted + EMIT_W'(1);
            pend_valid <= 1'b1;
          end else begin
            dropped <= 1'b1;
          end
        end
      end

      if (state == ST_FINISH && out_free) begin
        m_valid    <= 1'b1;
        in_run     <= 1'b0;
        emitted    <= '0;
        dropped    <= 1'b0;
        pend_valid <= 1'b0;
      end else if (state == ST_SCAN && s1_fire && push) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_col <= sc;
    end
    if (state == ST_SCAN && s1_fire) begin
      if (!in_run && nz) begin
        run_start <= s1_col[COL_W-1:0];
      end else if (produce) begin
        pend_start <= run_start;
        pend_end   <= s1_col;
      end
    end
    if (state == ST_FINISH && out_free) begin
      seg_start   <= pend_valid ? START_W'(pend_start) : '0;
      seg_end     <= pend_valid ? END_W'(pend_end) : '0;
      seg_valid   <= pend_valid;
      seg_final   <= 1'b1;
      seg_dropped <= dropped;
    end else if (state == ST_SCAN && s1_fire && push) begin
      seg_start   <= START_W'(pend_start);
      seg_end     <= END_W'(pend_end);
      seg_valid   <= 1'b1;
      seg_final   <= 1'b0;
      seg_dropped <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_emit_limit: assert property (@(posedge clk) disable iff (rst)
    emitted <= EMIT_MAX)
    else $error("segment count passed its limit");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !in_run && !pend_valid && !s1_valid)
    else $error("scan state left over in idle");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_en |-> state == ST_SCAN)
    else $error("column read outside the scan");

  a_finish_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_free |=> state == ST_IDLE && m_valid && seg_final)
    else $error("final result not loaded");
`endif

endmodule

// File: design/column_projection_segmenter_core.sv
// Vertical projection segmenter. Pixels of a binarized image enter on the
// s_axis channel, one per transaction in raster order; s_axis_tdata holds the
// pixel value. Each pixel equal to the foreground level adds one to its
// column's count (saturating at 2047) in a single-port-read column RAM,
// through a read-modify-write pipeline with forwarding, so one pixel is
// accepted every cycle while an image streams in.
// The image's last pixel starts the column scan: the flush state, then one
// RAM read per column over all MAX_COLUMNS entries, clearing the counts as it
// goes, one closing step past the last column, a drain of the read pipeline
// and the load of the final result in the finish state, which waits while
// m_axis is busy. s_axis_tready stays low from the last pixel until the final
// result is loaded, since the scan walks the one RAM read port.
// Results leave on m_axis, one transaction per run of non-empty columns up to
// MAX_SEGMENTS (later runs are dropped, flagged on the last result), or one
// empty result for an image without runs, with tlast on the last result of
// the image. A result waits in the output register while m_axis_tready is
// low, and the scan pauses behind it. Reset loads the register defaults and
// clears the column RAM in a pass over all MAX_COLUMNS entries, during which
// no pixel is accepted; configuration writes go through the cfg port at any
// time and should only change while the block is idle.
module column_projection_segmenter_core
  import cps_pkg::*;
#(
  parameter int MAX_COLUMNS  = 512,
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Pixel stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] pixel_value
  // Segment stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata,  // [8:0] segment_start, [18:9] segment_end
  output logic [1:0]             m_axis_tuser,  // [0] segment_valid, [1] segments_dropped
  output logic                   m_axis_tlast   // final_segment
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int WCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int HCNT_W = $clog2(MAX_ROWS + 1);

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [LEVEL_W-1:0]      foreground_level;

  logic [WCNT_W-1:0] w_eff;
  logic [HCNT_W-1:0] h_eff;

  ram_ctl_t           acc_ctl, scn_ctl, ram_ctl;
  logic [COL_W-1:0]   acc_raddr, acc_waddr, scn_addr, ram_raddr, ram_waddr;
  logic [COUNT_W-1:0] acc_wdata, ram_wdata, ram_rdata;
  logic               frame_end;
  logic               accept;
  logic               scan_idle;
  logic [START_W-1:0] seg_start;
  logic [END_W-1:0]   seg_end;
  logic               seg_valid;
  logic               seg_final;
  logic               seg_dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= WIDTH_RESET;
      image_height     <= HEIGHT_RESET;
      foreground_level <= LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:      image_width      <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT:     image_height     <= cfg_data[HEIGHT_REG_W-1:0];
        CFG_FOREGROUND_LEVEL: foreground_level <= cfg_data[LEVEL_W-1:0];
        default:              image_width      <= image_width;
      endcase
    end
  end

  // A zero size acts as one, and a size above the maximum acts as the maximum.
  always_comb begin
    if (image_width == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(image_width) > 32'(MAX_COLUMNS)) begin
      w_eff = WCNT_W'(MAX_COLUMNS);
    end else begin
      w_eff = WCNT_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HCNT_W'(1);
    end else if (32'(image_height) > 32'(MAX_ROWS)) begin
      h_eff = HCNT_W'(MAX_ROWS);
    end else begin
      h_eff = HCNT_W'(image_height);
    end
  end

  assign s_axis_tready = scan_idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cps_accum #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel     (s_axis_tdata),
    .fg_level  (foreground_level),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .rdata     (ram_rdata),
    .ctl       (acc_ctl),
    .raddr     (acc_raddr),
    .waddr     (acc_waddr),
    .wdata     (acc_wdata),
    .frame_end (frame_end)
  );

  cps_scan #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (frame_end),
    .w_eff       (w_eff),
    .rdata       (ram_rdata),
    .ctl         (scn_ctl),
    .addr        (scn_addr),
    .idle        (scan_idle),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .seg_start   (seg_start),
    .seg_end     (seg_end),
    .seg_valid   (seg_valid),
    .seg_final   (seg_final),
    .seg_dropped (seg_dropped)
  );

  // The accumulator owns the RAM while pixels stream and through the flush
  // cycle; the scan owns it while clearing and scanning. The scan writes zeros.
  assign ram_ctl.rd_en = acc_ctl.rd_en | scn_ctl.rd_en;
  assign ram_ctl.wr_en = acc_ctl.wr_en | scn_ctl.wr_en;
  assign ram_raddr     = acc_ctl.rd_en ? acc_raddr : scn_addr;
  assign ram_waddr     = acc_ctl.wr_en ? acc_waddr : scn_addr;
  assign ram_wdata     = acc_ctl.wr_en ? acc_wdata : '0;

  cps_count_ram #(
    .DEPTH (MAX_COLUMNS)
  ) u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_axis_tdata = {5'b0, seg_end, seg_start};
  assign m_axis_tuser = {seg_dropped, seg_valid};
  assign m_axis_tlast = seg_final;

endmodule

// File: sim/tb_column_projection_segmenter_core.sv
`timescale 1ns / 1ps

module tb_column_projection_segmenter_core;
  import cps_pkg::*;

  localparam int MAX_COLUMNS  = 512;
  localparam int MAX_ROWS     = 1024;
  localparam int MAX_SEGMENTS = 64;

  // The column scan walks every entry of the column store, so the block stays
  // busy through that walk after the last pixel of an image.
  localparam int SETTLE_CYCLES = MAX_COLUMNS + 64;

  // One expected segment result, one field per output of the block.
  typedef struct packed {
    logic [START_W-1:0] start_col;
    logic [END_W-1:0]   end_col;
    logic               carries_run;
    logic               closes_image;
    logic               dropped;
  } segment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  column_projection_segmenter_core #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // Pixels waiting to be driven, and the segments the block still owes us.
  logic [7:0]  pending_pixels[$];
  segment_t    expected_segments[$];
  int unsigned pixels_queued   = 0;
  int unsigned pixels_accepted = 0;
  int unsigned mismatch_count  = 0;

  // Percentages of cycles in which the pixel source idles and the segment
  // sink stalls. The stimulus changes them only while the block is quiet.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // ---------------------------------------------------------------------
  // Projection predictor: a private copy of the registers and of the
  // column store, advanced once per accepted pixel transaction.
  // ---------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  logic [LEVEL_W-1:0]      level_reg  = LEVEL_RESET;

  logic [COUNT_W-1:0] column_counts[MAX_COLUMNS];
  logic [8:0]         col_pos = '0;
  logic [9:0]         row_pos = '0;

  initial begin
    foreach (column_counts[i]) column_counts[i] = '0;
  end

  // A width or height of zero behaves as one; anything above the build
  // maximum behaves as the maximum.
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic tally_pixel(input logic [7:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned emitted;
    int unsigned run_start;
    bit          open_run;
    bit          nonempty;
    bit          lost_runs;
    segment_t    seg;
    w = clamp_dim(width_reg, MAX_COLUMNS);
    h = clamp_dim(height_reg, MAX_ROWS);

    // Ink pixels bump their column, saturating at the counter's maximum.
    if (px == level_reg && col_pos < MAX_COLUMNS && column_counts[col_pos] < COUNT_MAX)
      column_counts[col_pos] = column_counts[col_pos] + 1'b1;

    // A position left at or past the last column or row by a register
    // change simply wraps here.
    if (col_pos + 1 < w) begin
      col_pos = col_pos + 1'b1;
      return;
    end
    col_pos = '0;
    if (row_pos + 1 < h) begin
      row_pos = row_pos + 1'b1;
      return;
    end
    row_pos = '0;

    // Last pixel of the image: scan columns 0..w-1. Position w is treated
    // as an empty column so that a run touching the right edge ends at w.
    open_run  = 1'b0;
    lost_runs = 1'b0;
    emitted   = 0;
    run_start = 0;
    for (c = 0; c <= w; c++) begin
      nonempty = (c < w) && (column_counts[c] != '0);
      if (!open_run && nonempty) begin
        open_run  = 1'b1;
        run_start = c;
      end else if (open_run && !nonempty) begin
        open_run = 1'b0;
        if (emitted < MAX_SEGMENTS) begin
          seg              = '0;
          seg.start_col    = run_start[START_W-1:0];
          seg.end_col      = c[END_W-1:0];
          seg.carries_run  = 1'b1;
          expected_segments.insert(expected_segments.size(), seg);
          emitted++;
        end else begin
          lost_runs = 1'b1;
        end
      end
    end

    // The scan empties the whole store, including columns past the width.
    foreach (column_counts[i]) column_counts[i] = '0;

    // An image without ink still ends with one result, marked empty.
    if (emitted == 0) expected_segments.insert(expected_segments.size(), '0);
    seg              = expected_segments.pop_back();
    seg.closes_image = 1'b1;
    seg.dropped      = lost_runs;
    expected_segments.insert(expected_segments.size(), seg);
  endtask

  // ---------------------------------------------------------------------
  // Pixel driver. A new pixel is offered whenever the previous transaction
  // has completed or nothing was on the bus; on idle cycles tvalid drops.
  // The predictor runs on the clock edge at which a transaction completes.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        tally_pixel(s_axis_tdata);
        pixels_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= pending_pixels.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Segment monitor. Every completed result transaction is compared field
  // by field with the oldest expected segment.
  // ---------------------------------------------------------------------
  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : segment_monitor
    segment_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_segments.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = expected_segments.pop_front();
          compare_field("segment_start", want.start_col, m_axis_tdata[8:0]);
          compare_field("segment_end", want.end_col, m_axis_tdata[18:9]);
          compare_field("segment_valid", want.carries_run, m_axis_tuser[0]);
          compare_field("segments_dropped", want.dropped, m_axis_tuser[1]);
          compare_field("final_segment", want.closes_image, m_axis_tlast);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic queue_pixel(input logic [7:0] value);
    pending_pixels.insert(pending_pixels.size(), value);
    pixels_queued++;
  endtask

  // Queues one full image. Columns marked in ink_cols receive ink with the
  // given probability; every other pixel is a random non-ink value.
  task automatic queue_image(input int unsigned w, input int unsigned h,
                             input logic [MAX_COLUMNS-1:0] ink_cols,
                             input int unsigned ink_pct);
    int unsigned r;
    int unsigned c;
    logic [7:0]  noise;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        noise = 8'($urandom_range(255));
        if (noise == level_reg) noise = ~noise;
        if (ink_cols[c] && $urandom_range(99) < ink_pct) queue_pixel(level_reg);
        else queue_pixel(noise);
      end
    end
  endtask

  // Waits until every queued pixel went through, every expected segment
  // arrived, and the scan machinery had time to wind down. Returns on a
  // falling edge so that later queue and register updates never share a
  // time step with the clocked driver.
  task automatic drain();
    while (pixels_accepted != pixels_queued) @(posedge clk);
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (index)
      CFG_IMAGE_WIDTH:      width_reg  = value[WIDTH_REG_W-1:0];
      CFG_IMAGE_HEIGHT:     height_reg = value[HEIGHT_REG_W-1:0];
      CFG_FOREGROUND_LEVEL: level_reg  = value[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // Registers change only once the block has gone quiet.
  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned level);
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_FOREGROUND_LEVEL, CFG_DATA_W'(level));
    @(negedge clk);
  endtask

  // Queues n pixels, each one ink or noise at random.
  task automatic queue_partial(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(1) == 1) queue_pixel(level_reg);
      else queue_pixel(~level_reg);
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [MAX_COLUMNS-1:0] alternating;
    logic [MAX_COLUMNS-1:0] ink_cols;
    int unsigned            phase;
    int unsigned            part;
    int unsigned            w;
    int unsigned            h;
    int unsigned            level;
    int unsigned            goal;
    int unsigned            c;

    alternating = {(MAX_COLUMNS / 2){2'b01}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, with moderate idling on both sides.
    send_idle_pct  = 31;
    recv_stall_pct = 31;

    // Small image: interior runs, a single-column run and a run that is
    // still open at the right edge; then an empty image and a full one.
    configure(8, 2, 255);
    queue_image(8, 2, 512'hA6, 100);
    queue_image(8, 2, '0, 100);
    queue_image(8, 2, '1, 100);

    // One-pixel images with and without ink.
    configure(1, 1, 255);
    queue_image(1, 1, 512'h1, 100);
    queue_image(1, 1, '0, 100);

    // Zero width and height behave as one; pixel value zero as the ink.
    configure(0, 0, 0);
    queue_image(1, 1, 512'h1, 100);
    configure(4, 3, 0);
    queue_image(4, 3, 512'h9, 100);

    // Alternating columns give one run more than the segment limit, the last
    // one touching the right edge, so it is dropped and flagged.
    configure(2 * MAX_SEGMENTS + 1, 1, 255);
    queue_image(2 * MAX_SEGMENTS + 1, 1, alternating, 100);

    // Width shrunk in the middle of an image: the column position lies past
    // the new last column and wraps at the next pixel, which here is also
    // the last row, so the scan covers only the new width.
    configure(8, 2, 255);
    queue_partial(13);
    configure(4, 2, 255);
    queue_partial(1);
    // Columns past the old scan width must have been cleared too.
    configure(8, 1, 255);
    queue_image(8, 1, '0, 100);

    // Height shrunk in the middle of an image: the row position lies past
    // the new last row and the image ends at the end of that row.
    configure(4, 4, 255);
    queue_partial(10);
    configure(4, 2, 255);
    queue_partial(2);

    // Random part: four idling phases, two register settings in each.
    // Every setting ends with a drain, so the source also waits for all
    // outstanding results before the next setting starts.
    for (phase = 0; phase < 4; phase++) begin
      for (part = 0; part < 2; part++) begin
        if (phase == 2 && part == 1) begin
          w = $urandom_range(32, 96);
          h = 1;
        end else begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 3);
        end
        case ($urandom_range(3))
          0:       level = 0;
          1:       level = 255;
          default: level = $urandom_range(255);
        endcase
        configure(w, h, level);
        case (phase)
          0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
          end
          1: begin
            send_idle_pct  = 48;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 48;
          end
          default: begin
            send_idle_pct  = 31;
            recv_stall_pct = 31;
          end
        endcase
        goal = pixels_queued + 10;
        while (pixels_queued < goal) begin
          for (c = 0; c < MAX_COLUMNS; c++) ink_cols[c] = ($urandom_range(99) < 55);
          queue_image(w, h, ink_cols, $urandom_range(20, 100));
        end
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("[column_projection_segmenter_core] OK");
    end else begin
      $display("[column_projection_segmenter_core] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #4000000;
    $display("[column_projection_segmenter_core] ERROR");
    $finish;
  end

endmodule
